/* hw/rtl/i8dpr_pkg.sv */
// ============================================================================
// i8dpr_pkg
// Shared types and constants for the int8 dot product requantization core.
// ============================================================================
package i8dpr_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ZERO_POINT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELU_ENABLE       = 1'd1;

    localparam logic signed [32:0] SAT_MAX = 33'sd127;
    localparam logic signed [32:0] SAT_MIN = -33'sd128;

    typedef struct packed {
        logic acc_en;
        logic capture;
        logic bias_add;
        logic mul_en;
        logic shift_en;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

/* hw/rtl/i8dpr_in_if.sv */
// ============================================================================
// i8dpr_in_if
// Input channel carrying one activation and weight pair per transaction.
// ============================================================================
interface i8dpr_in_if;
    logic               valid;
    logic               ready;
    logic signed [7:0]  activation_value;
    logic signed [7:0]  weight_value;
    logic               last_element;
    logic signed [31:0] bias_value;
    logic signed [31:0] scale_multiplier;
    logic        [5:0]  scale_shift;

    modport source (
        output valid, activation_value, weight_value, last_element,
               bias_value, scale_multiplier, scale_shift,
        input  ready
    );

    modport sink (
        input  valid, activation_value, weight_value, last_element,
               bias_value, scale_multiplier, scale_shift,
        output ready
    );
endinterface

/* hw/rtl/i8dpr_out_if.sv */
// ============================================================================
// i8dpr_out_if
// Output channel carrying one requantized int8 result per transaction.
// ============================================================================
interface i8dpr_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] quantized_result;

    modport source (
        output valid, quantized_result,
        input  ready
    );

    modport sink (
        input  valid, quantized_result,
        output ready
    );
endinterface

/* hw/rtl/i8dpr_ctrl.sv */
// ============================================================================
// i8dpr_ctrl
// Sequencer that steps each finished run through bias, scaling and output.
// ============================================================================
module i8dpr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_last,
    output logic                  o_in_ready,
    input  i8dpr_pkg::t_dp_status i_status,
    output i8dpr_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BIAS  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       in_fire;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.acc_en   = in_fire;
        o_cmd.capture  = in_fire && i_in_last;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && i_in_last) begin
                    n_state = ST_BIAS;
                end
            end
            ST_BIAS: begin
                o_cmd.bias_add = 1'b1;
                n_state        = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = ST_SHIFT;
            end
            ST_SHIFT: begin
                o_cmd.shift_en = 1'b1;
                n_state        = ST_FIN;
            end
            ST_FIN: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/i8dpr_datapath.sv */
// ============================================================================
// i8dpr_datapath
// Accumulator, requantization pipeline registers and output register.
// ============================================================================
module i8dpr_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [i8dpr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [i8dpr_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic signed [7:0]                      i_activation_value,
    input  logic signed [7:0]                      i_weight_value,
    input  logic signed [31:0]                     i_bias_value,
    input  logic signed [31:0]                     i_scale_multiplier,
    input  logic        [5:0]                      i_scale_shift,
    input  i8dpr_pkg::t_dp_cmd                     i_cmd,
    output i8dpr_pkg::t_dp_status                  o_status,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [7:0]                      o_quantized_result
);

    logic signed [7:0]  r_zero_point;
    logic               r_relu_en;
    logic        [31:0] r_sum;
    logic signed [31:0] r_bias;
    logic signed [31:0] r_mult;
    logic        [5:0]  r_shift;
    logic signed [31:0] r_total;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_q;
    logic               r_out_valid;
    logic signed [7:0]  r_out_data;

    logic signed [15:0] pair_prod;
    logic signed [63:0] shifted;
    logic signed [31:0] rect;
    logic signed [32:0] with_zp;
    logic signed [7:0]  sat;

    assign pair_prod = 16'(i_activation_value) * 16'(i_weight_value);
    assign shifted   = r_prod >>> r_shift;

    always_comb begin
        rect    = (r_relu_en && r_q[31]) ? 32'sd0 : r_q;
        with_zp = 33'(rect) + 33'(r_zero_point);
        if (with_zp > i8dpr_pkg::SAT_MAX) begin
            sat = 8'sd127;
        end else if (with_zp < i8dpr_pkg::SAT_MIN) begin
            sat = -8'sd128;
        end else begin
            sat = with_zp[7:0];
        end
    end

    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_quantized_result = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_point <= '0;
            r_relu_en    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                i8dpr_pkg::CFG_OUTPUT_ZERO_POINT: r_zero_point <= i_cfg_wdata;
                i8dpr_pkg::CFG_RELU_ENABLE:       r_relu_en    <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_cmd.bias_add) begin
            r_sum <= '0;
        end else if (i_cmd.acc_en) begin
            r_sum <= r_sum + {{16{pair_prod[15]}}, pair_prod};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_bias  <= i_bias_value;
            r_mult  <= i_scale_multiplier;
            r_shift <= i_scale_shift;
        end
        if (i_cmd.bias_add) begin
            r_total <= r_sum + r_bias;
        end
        if (i_cmd.mul_en) begin
            r_prod <= 64'(r_total) * 64'(r_mult);
        end
        if (i_cmd.shift_en) begin
            r_q <= shifted[31:0];
        end
        if (i_cmd.out_load) begin
            r_out_data <= sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

/* hw/rtl/int8_dot_product_requantize_core.sv */
// ============================================================================
// int8_dot_product_requantize_core
// Signed int8 dot product with int32 bias and fixed-point requantization.
//
// The input channel takes one activation and weight pair per transaction.
// Each pair is multiplied and added into a wrapping 32-bit accumulator.
// A pair that is not last produces no result, and such pairs are taken
// at one per clock cycle while the block is idle.
// The pair marked last also carries the bias, the multiplier and the shift.
// After it is accepted the block adds the bias, multiplies and shifts in
// registered steps, then rectifies, adds the zero point and saturates
// combinationally as the result is loaded into the output register.
// The input channel is held off from the last pair until that load.
// The output register holds a finished result while the receiver stalls;
// pairs of the next run are still taken, but a second finished run waits
// until the held result has been taken.
// Configuration writes take effect on the next cycle; the user must make
// them while the block is idle, as the block itself does not enforce it.
// Reset clears the accumulator, the configuration and the output valid.
// ============================================================================
module int8_dot_product_requantize_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [i8dpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [i8dpr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    i8dpr_in_if.sink                         i_pair,
    i8dpr_out_if.source                      o_res
);

    i8dpr_pkg::t_dp_cmd    dp_cmd;
    i8dpr_pkg::t_dp_status dp_status;

    i8dpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pair.valid),
        .i_in_last  (i_pair.last_element),
        .o_in_ready (i_pair.ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    i8dpr_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_activation_value (i_pair.activation_value),
        .i_weight_value     (i_pair.weight_value),
        .i_bias_value       (i_pair.bias_value),
        .i_scale_multiplier (i_pair.scale_multiplier),
        .i_scale_shift      (i_pair.scale_shift),
        .i_cmd              (dp_cmd),
        .o_status           (dp_status),
        .i_out_ready        (o_res.ready),
        .o_out_valid        (o_res.valid),
        .o_quantized_result (o_res.quantized_result)
    );

endmodule
